// ----- rtl/core/efc_pkg.sv -----
`default_nettype none
package efc_pkg;

	localparam int ENDPOINTS = 8;
	localparam int EP_IDX_W = $clog2(ENDPOINTS);

	localparam logic [1:0] MODE_ENQ   = 2'd0;
	localparam logic [1:0] MODE_DEQ   = 2'd1;
	localparam logic [1:0] MODE_GRANT = 2'd2;

	localparam logic [1:0] REG_CREDIT_SIZE = 2'd0;
	localparam logic [1:0] REG_FLOW_MASK   = 2'd1;
	localparam logic [1:0] REG_DEPTH       = 2'd2;
	localparam logic [1:0] REG_CPM         = 2'd3;

	localparam logic [15:0] CREDIT_SIZE_RST = 16'd1;
	localparam logic [7:0]  FLOW_MASK_RST   = 8'hFF;
	localparam logic [15:0] CNT_MAX         = 16'hFFFF;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic commit;
	} efc_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} efc_sts_t;

	typedef struct packed {
		logic [15:0] cnt;
		logic        stopped;
		logic        stop_ev;
		logic        wake_ev;
	} efc_rc_t;

	// queue count step with stop at limit and wake at half limit
	function automatic efc_rc_t efc_recalc(input logic [7:0] lim, input logic [15:0] cnt,
			input logic stopped, input logic up);
		efc_rc_t r;
		r.cnt = cnt;
		r.stopped = stopped;
		r.stop_ev = 1'b0;
		r.wake_ev = 1'b0;
		if (lim != 8'd0) begin
			if (up) begin
				if (cnt != CNT_MAX)
					r.cnt = cnt + 16'd1;
			end else if (cnt != 16'd0) begin
				r.cnt = cnt - 16'd1;
			end
			if (stopped) begin
				if (r.cnt <= {9'd0, lim[7:1]}) begin
					r.stopped = 1'b0;
					r.wake_ev = 1'b1;
				end
			end else if (r.cnt >= {8'd0, lim}) begin
				r.stopped = 1'b1;
				r.stop_ev = 1'b1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/efc_div.sv -----
`default_nettype none
module efc_div import efc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [15:0]      quot,
	output logic [15:0]      rem
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [16:0] shifted;
	logic [16:0] diff;
	logic        bit_ok;

	// one restoring step per cycle
	assign shifted = {rem_q, quo_q[15]};
	assign diff = shifted - {1'b0, div_q};
	assign bit_ok = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 16'd0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[14:0], bit_ok};
			rem_q <= bit_ok ? diff[15:0] : shifted[15:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem = rem_q;

endmodule
`default_nettype wire

// ----- rtl/core/efc_ctrl.sv -----
`default_nettype none
module efc_ctrl import efc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  efc_sts_t  sts,
	output efc_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DISP = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_EXEC = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = ST_WAIT;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_WAIT: begin
				if (sts.div_done)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_div_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) && sts.div_done |=> (state_q == ST_EXEC))
		else $error("divider result not consumed");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while output register is full");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in work");

	a_start_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> $past(cmd.capture))
		else $error("divide started without a fresh transaction");

endmodule
`default_nettype wire

// ----- rtl/core/efc_dp.sv -----
`default_nettype none
module efc_dp import efc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  efc_cmd_t         cmd,
	output efc_sts_t         sts,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic [1:0]  mode,
	input  wire logic [2:0]  endpoint,
	input  wire logic        head_valid,
	input  wire logic [15:0] packet_length,
	input  wire logic        resources_available,
	input  wire logic [7:0]  credit_amount,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             granted,
	output logic [15:0]      charged_credits,
	output logic [7:0]       sequence_number,
	output logic             need_credit_update,
	output logic             queue_stopped,
	output logic             stop_event,
	output logic             wake_event,
	output logic             kick_sender
);

	localparam logic [3:0] EP_COUNT = 4'(ENDPOINTS);

	logic [15:0] credit_size_q;
	logic [7:0]  flow_mask_q;
	logic [63:0] depth_q;
	logic [63:0] cpm_q;

	logic [15:0] credit_q [ENDPOINTS];
	logic [15:0] qcnt_q   [ENDPOINTS];
	logic        stop_q   [ENDPOINTS];
	logic [7:0]  seq_q    [ENDPOINTS];

	logic [1:0]  mode_q;
	logic [2:0]  ep_q;
	logic        head_q;
	logic [15:0] len_q;
	logic        res_q;
	logic [7:0]  amount_q;

	logic        out_valid_q;
	logic        granted_q;
	logic [15:0] used_q;
	logic [7:0]  seqno_q;
	logic        ncu_q;
	logic        stopped_q;
	logic        stop_ev_q;
	logic        wake_ev_q;
	logic        kick_q;

	logic [EP_IDX_W-1:0] idx;
	logic        oor;
	logic        flow;
	logic [7:0]  lim;
	logic [7:0]  cpm;
	logic [15:0] divisor;
	logic        div_done;
	logic [15:0] quot;
	logic [15:0] rem;
	logic [15:0] q_adj;
	logic [15:0] need;
	logic [16:0] cred_sum;
	efc_rc_t     rc_a;
	efc_rc_t     rc_b;
	efc_rc_t     rc_fin;
	logic        g;
	logic [15:0] cred_new;
	logic [15:0] used_d;
	logic        ncu_d;
	logic        kick_d;

	assign idx = ep_q[EP_IDX_W-1:0];
	assign oor = {1'b0, ep_q} >= EP_COUNT;
	assign flow = flow_mask_q[ep_q];
	assign lim = depth_q[ep_q*8 +: 8];
	assign cpm = cpm_q[ep_q*8 +: 8];
	assign divisor = (credit_size_q == 16'd0) ? 16'd1 : credit_size_q;

	efc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (len_q),
		.divisor  (divisor),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	// ceiling of length over credit size, at least one credit
	assign q_adj = quot + {15'd0, rem != 16'd0};
	assign need = (q_adj == 16'd0) ? 16'd1 : q_adj;
	assign cred_sum = {1'b0, credit_q[idx]} + {9'd0, amount_q};

	assign sts.need_div = !oor && (mode_q == MODE_DEQ) && flow && head_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		rc_a = efc_recalc(lim, qcnt_q[idx], stop_q[idx], 1'b0);
		rc_b = efc_recalc(lim, rc_a.cnt, rc_a.stopped, 1'b1);
		rc_fin = '{cnt: qcnt_q[idx], stopped: stop_q[idx], stop_ev: 1'b0, wake_ev: 1'b0};
		g = 1'b0;
		cred_new = credit_q[idx];
		used_d = 16'd0;
		ncu_d = 1'b0;
		kick_d = 1'b0;
		unique case (mode_q)
			MODE_ENQ: rc_fin = efc_recalc(lim, qcnt_q[idx], stop_q[idx], 1'b1);
			MODE_DEQ: begin
				if (flow) begin
					if (head_q) begin
						if (idx == '0) begin
							g = 1'b1;
							rc_fin = rc_a;
						end else if (credit_q[idx] < need) begin
							// short on credits: requeue, events of both steps show
							rc_fin.cnt = rc_b.cnt;
							rc_fin.stopped = rc_b.stopped;
							rc_fin.stop_ev = rc_a.stop_ev | rc_b.stop_ev;
							rc_fin.wake_ev = rc_a.wake_ev | rc_b.wake_ev;
						end else begin
							g = 1'b1;
							rc_fin = rc_a;
							cred_new = credit_q[idx] - need;
							used_d = need;
						end
						ncu_d = g && (cred_new < {8'd0, cpm});
					end
				end else if (res_q && head_q) begin
					g = 1'b1;
					rc_fin = rc_a;
				end
			end
			MODE_GRANT: begin
				cred_new = cred_sum[16] ? CNT_MAX : cred_sum[15:0];
				kick_d = (cred_new != 16'd0) && head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_size_q <= CREDIT_SIZE_RST;
			flow_mask_q <= FLOW_MASK_RST;
			depth_q <= 64'd0;
			cpm_q <= 64'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CREDIT_SIZE: credit_size_q <= cfg_data[15:0];
				REG_FLOW_MASK:   flow_mask_q <= cfg_data[7:0];
				REG_DEPTH:       depth_q <= cfg_data;
				REG_CPM:         cpm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENDPOINTS; i++) begin
				credit_q[i] <= 16'd0;
				qcnt_q[i] <= 16'd0;
				stop_q[i] <= 1'b0;
				seq_q[i] <= 8'd0;
			end
		end else if (cmd.commit && !oor) begin
			credit_q[idx] <= cred_new;
			qcnt_q[idx] <= rc_fin.cnt;
			stop_q[idx] <= rc_fin.stopped;
			if (g)
				seq_q[idx] <= seq_q[idx] + 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			ep_q <= endpoint;
			head_q <= head_valid;
			len_q <= packet_length;
			res_q <= resources_available;
			amount_q <= credit_amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q <= g && !oor;
			used_q <= oor ? 16'd0 : used_d;
			seqno_q <= (g && !oor) ? seq_q[idx] : 8'd0;
			ncu_q <= ncu_d && !oor;
			stopped_q <= rc_fin.stopped && !oor;
			stop_ev_q <= rc_fin.stop_ev && !oor;
			wake_ev_q <= rc_fin.wake_ev && !oor;
			kick_q <= kick_d && !oor;
		end
	end

	assign out_valid = out_valid_q;
	assign granted = granted_q;
	assign charged_credits = used_q;
	assign sequence_number = seqno_q;
	assign need_credit_update = ncu_q;
	assign queue_stopped = stopped_q;
	assign stop_event = stop_ev_q;
	assign wake_event = wake_ev_q;
	assign kick_sender = kick_q;

endmodule
`default_nettype wire

// ----- rtl/core/endpoint_credit_flow_control.sv -----
// one transaction in work at a time; after acceptance it passes the dispatch state, then the
// execute state commits the result to the output register once that register is free, and a
// credit-mode dequeue with a valid head waits between them for the 16-step serial divider
// next transaction is accepted the cycle after the result is committed to the output register
// arst_n clears all per-endpoint counters, flags and sequence numbers at once and loads
// register defaults: credit size 1, all endpoints in credit flow, no depth tracking
`default_nettype none
module endpoint_credit_flow_control import efc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [2:0]  endpoint,
	input  wire logic        head_valid,
	input  wire logic [15:0] packet_length,
	input  wire logic        resources_available,
	input  wire logic [7:0]  credit_amount,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             granted,
	output logic [15:0]      charged_credits,
	output logic [7:0]       sequence_number,
	output logic             need_credit_update,
	output logic             queue_stopped,
	output logic             stop_event,
	output logic             wake_event,
	output logic             kick_sender
);

	efc_cmd_t cmd;
	efc_sts_t sts;

	efc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	efc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.mode                (mode),
		.endpoint            (endpoint),
		.head_valid          (head_valid),
		.packet_length       (packet_length),
		.resources_available (resources_available),
		.credit_amount       (credit_amount),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.granted             (granted),
		.charged_credits     (charged_credits),
		.sequence_number     (sequence_number),
		.need_credit_update  (need_credit_update),
		.queue_stopped       (queue_stopped),
		.stop_event          (stop_event),
		.wake_event          (wake_event),
		.kick_sender         (kick_sender)
	);

endmodule
`default_nettype wire

// ----- bench/endpoint_credit_flow_control_tb.sv -----
`default_nettype none
module endpoint_credit_flow_control_tb;
	import efc_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd3;

	typedef struct {
		logic [1:0]  mode;
		logic [2:0]  endpoint;
		logic        head_valid;
		logic [15:0] packet_length;
		logic        resources_available;
		logic [7:0]  credit_amount;
		bit          drain_first;
	} credit_event_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] charged_credits;
		logic [7:0]  sequence_number;
		logic        need_credit_update;
		logic        queue_stopped;
		logic        stop_event;
		logic        wake_event;
		logic        kick_sender;
	} release_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_CREDIT_SIZE;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_ENQ;
	logic [2:0]  endpoint = '0;
	logic        head_valid = 1'b0;
	logic [15:0] packet_length = '0;
	logic        resources_available = 1'b0;
	logic [7:0]  credit_amount = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        granted;
	logic [15:0] charged_credits;
	logic [7:0]  sequence_number;
	logic        need_credit_update;
	logic        queue_stopped;
	logic        stop_event;
	logic        wake_event;
	logic        kick_sender;

	endpoint_credit_flow_control dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.mode               (mode),
		.endpoint           (endpoint),
		.head_valid         (head_valid),
		.packet_length      (packet_length),
		.resources_available(resources_available),
		.credit_amount      (credit_amount),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.granted            (granted),
		.charged_credits    (charged_credits),
		.sequence_number    (sequence_number),
		.need_credit_update (need_credit_update),
		.queue_stopped      (queue_stopped),
		.stop_event         (stop_event),
		.wake_event         (wake_event),
		.kick_sender        (kick_sender)
	);

	// predictor copy of the per-endpoint state and the registers
	logic [15:0] ep_credits [ENDPOINTS];
	logic [15:0] ep_depth [ENDPOINTS];
	logic        ep_stopped [ENDPOINTS];
	logic [7:0]  ep_seq [ENDPOINTS];
	logic [15:0] cur_credit_size;
	logic [7:0]  cur_flow_mask;
	logic [63:0] cur_depth_limits;
	logic [63:0] cur_credits_per_msg;

	credit_event_t   event_backlog[$];
	release_status_t expected_status_q[$];
	credit_event_t   next_ev;
	credit_event_t   seen_ev;
	release_status_t want_status;
	release_status_t got_status;
	bit              ev_taken = 1'b0;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              error_count = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic step_depth(input int e, input bit up, inout bit stop_ev, inout bit wake_ev);
		logic [7:0] lim;
		lim = cur_depth_limits[e*8 +: 8];
		if (lim == 8'd0)
			return;
		if (up) begin
			if (ep_depth[e] != 16'hFFFF)
				ep_depth[e] = ep_depth[e] + 16'd1;
		end else if (ep_depth[e] != 16'd0) begin
			ep_depth[e] = ep_depth[e] - 16'd1;
		end
		if (ep_stopped[e]) begin
			if (ep_depth[e] <= {9'd0, lim[7:1]}) begin
				ep_stopped[e] = 1'b0;
				wake_ev = 1'b1;
			end
		end else if (ep_depth[e] >= {8'd0, lim}) begin
			ep_stopped[e] = 1'b1;
			stop_ev = 1'b1;
		end
	endtask

	task automatic apply_credit_event(input credit_event_t ev, output release_status_t st);
		int          e;
		bit          stop_ev;
		bit          wake_ev;
		int unsigned cs;
		int unsigned need;
		int unsigned sum;
		st = '0;
		stop_ev = 1'b0;
		wake_ev = 1'b0;
		e = ev.endpoint;
		case (ev.mode)
			MODE_ENQ: begin
				step_depth(e, 1'b1, stop_ev, wake_ev);
			end
			MODE_DEQ: begin
				if (cur_flow_mask[e]) begin
					if (ev.head_valid) begin
						cs = (cur_credit_size == 16'd0) ? 1 : cur_credit_size;
						need = (ev.packet_length + cs - 1) / cs;
						if (need == 0)
							need = 1;
						step_depth(e, 1'b0, stop_ev, wake_ev);
						if (e == 0) begin
							need = 0;
							st.granted = 1'b1;
						end else if (ep_credits[e] < need) begin
							// short on credits: the packet goes back to the queue
							step_depth(e, 1'b1, stop_ev, wake_ev);
						end else begin
							ep_credits[e] = ep_credits[e] - need[15:0];
							st.granted = 1'b1;
						end
						if (st.granted) begin
							st.charged_credits = need[15:0];
							st.need_credit_update = ep_credits[e] < cur_credits_per_msg[e*8 +: 8];
						end
					end
				end else if (ev.resources_available && ev.head_valid) begin
					step_depth(e, 1'b0, stop_ev, wake_ev);
					st.granted = 1'b1;
				end
				if (st.granted) begin
					st.sequence_number = ep_seq[e];
					ep_seq[e] = ep_seq[e] + 8'd1;
				end
			end
			MODE_GRANT: begin
				sum = ep_credits[e] + ev.credit_amount;
				if (sum > 65535)
					sum = 65535;
				ep_credits[e] = sum[15:0];
				st.kick_sender = (sum != 0) && ev.head_valid;
			end
			default: begin
			end
		endcase
		st.queue_stopped = ep_stopped[e];
		st.stop_event = stop_ev;
		st.wake_event = wake_ev;
	endtask

	task automatic check_status(input release_status_t exp, input release_status_t act);
		if (act.granted !== exp.granted) begin
			$error("granted: expected %0d, got %0d", exp.granted, act.granted);
			error_count++;
		end
		if (act.charged_credits !== exp.charged_credits) begin
			$error("charged_credits: expected %0d, got %0d", exp.charged_credits,
				act.charged_credits);
			error_count++;
		end
		if (act.sequence_number !== exp.sequence_number) begin
			$error("sequence_number: expected %0d, got %0d", exp.sequence_number,
				act.sequence_number);
			error_count++;
		end
		if (act.need_credit_update !== exp.need_credit_update) begin
			$error("need_credit_update: expected %0d, got %0d", exp.need_credit_update,
				act.need_credit_update);
			error_count++;
		end
		if (act.queue_stopped !== exp.queue_stopped) begin
			$error("queue_stopped: expected %0d, got %0d", exp.queue_stopped, act.queue_stopped);
			error_count++;
		end
		if (act.stop_event !== exp.stop_event) begin
			$error("stop_event: expected %0d, got %0d", exp.stop_event, act.stop_event);
			error_count++;
		end
		if (act.wake_event !== exp.wake_event) begin
			$error("wake_event: expected %0d, got %0d", exp.wake_event, act.wake_event);
			error_count++;
		end
		if (act.kick_sender !== exp.kick_sender) begin
			$error("kick_sender: expected %0d, got %0d", exp.kick_sender, act.kick_sender);
			error_count++;
		end
	endtask

	// driver: payload changes only at the falling edge
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !ev_taken)) begin
			ev_taken = 1'b0;
			if (event_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
					&& (!event_backlog[0].drain_first || expected_status_q.size() == 0)) begin
				next_ev = event_backlog.pop_front();
				mode <= next_ev.mode;
				endpoint <= next_ev.endpoint;
				head_valid <= next_ev.head_valid;
				packet_length <= next_ev.packet_length;
				resources_available <= next_ev.resources_available;
				credit_amount <= next_ev.credit_amount;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// monitor: results first so a same-edge transaction cannot match itself
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_status = {granted, charged_credits, sequence_number, need_credit_update,
					queue_stopped, stop_event, wake_event, kick_sender};
				if (expected_status_q.size() == 0) begin
					$error("result with no transaction outstanding");
					error_count++;
				end else begin
					check_status(expected_status_q.pop_front(), got_status);
				end
			end
			if (in_valid && in_ready) begin
				seen_ev.mode = mode;
				seen_ev.endpoint = endpoint;
				seen_ev.head_valid = head_valid;
				seen_ev.packet_length = packet_length;
				seen_ev.resources_available = resources_available;
				seen_ev.credit_amount = credit_amount;
				seen_ev.drain_first = 1'b0;
				apply_credit_event(seen_ev, want_status);
				expected_status_q.push_back(want_status);
				ev_taken = 1'b1;
			end
		end
	end

	task automatic add_event(input logic [1:0] m, input logic [2:0] e, input logic hv,
			input logic [15:0] len, input logic res, input logic [7:0] amt, input bit drain);
		credit_event_t ev;
		ev.mode = m;
		ev.endpoint = e;
		ev.head_valid = hv;
		ev.packet_length = len;
		ev.resources_available = res;
		ev.credit_amount = amt;
		ev.drain_first = drain;
		event_backlog.push_back(ev);
	endtask

	task automatic wait_idle();
		while (event_backlog.size() != 0 || in_valid || expected_status_q.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_CREDIT_SIZE: cur_credit_size = val[15:0];
			REG_FLOW_MASK:   cur_flow_mask = val[7:0];
			REG_DEPTH:       cur_depth_limits = val;
			REG_CPM:         cur_credits_per_msg = val;
			default: begin
			end
		endcase
	endtask

	task automatic load_config(input logic [15:0] cs, input logic [7:0] mask,
			input logic [63:0] depth, input logic [63:0] cpm);
		wait_idle();
		write_reg(REG_CREDIT_SIZE, {48'd0, cs});
		write_reg(REG_FLOW_MASK, {56'd0, mask});
		write_reg(REG_DEPTH, depth);
		write_reg(REG_CPM, cpm);
	endtask

	initial begin
		int          n;
		int          cnt;
		int unsigned sel;
		int unsigned top;
		logic [2:0]  e;
		logic [15:0] len;
		logic [63:0] lims;
		cur_credit_size = CREDIT_SIZE_RST;
		cur_flow_mask = FLOW_MASK_RST;
		cur_depth_limits = '0;
		cur_credits_per_msg = '0;
		for (int i = 0; i < ENDPOINTS; i++) begin
			ep_credits[i] = '0;
			ep_depth[i] = '0;
			ep_stopped[i] = 1'b0;
			ep_seq[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero credit size acts as one; endpoint 3 runs without credit flow
		load_config(16'd0, 8'hF7, 64'h0000_0000_0400_0200, 64'h0000_0000_0000_FF00);
		add_event(MODE_GRANT, 3'd1, 1'b1, 16'd0, 1'b0, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd1, 1'b1, 16'd0, 1'b0, 8'd0, 1'b0);
		add_event(MODE_ENQ, 3'd1, 1'b0, 16'd0, 1'b0, 8'd0, 1'b0);
		add_event(MODE_GRANT, 3'd1, 1'b1, 16'd0, 1'b0, 8'd255, 1'b0);
		add_event(MODE_GRANT, 3'd1, 1'b0, 16'd0, 1'b0, 8'd255, 1'b0);
		add_event(MODE_DEQ, 3'd1, 1'b1, 16'hFFFF, 1'b0, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd1, 1'b1, 16'd2, 1'b0, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd0, 1'b1, 16'd100, 1'b0, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd0, 1'b0, 16'd0, 1'b0, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd3, 1'b1, 16'd7, 1'b1, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd3, 1'b1, 16'd7, 1'b0, 8'd0, 1'b0);
		add_event(MODE_DEQ, 3'd3, 1'b0, 16'd7, 1'b1, 8'd0, 1'b0);
		add_event(MODE_IDLE, 3'd1, 1'b1, 16'hFFFF, 1'b1, 8'd255, 1'b0);
		add_event(MODE_ENQ, 3'd7, 1'b1, 16'hFFFF, 1'b1, 8'd255, 1'b0);
		add_event(MODE_GRANT, 3'd7, 1'b1, 16'hFFFF, 1'b1, 8'd255, 1'b0);
		add_event(MODE_DEQ, 3'd7, 1'b1, 16'd255, 1'b1, 8'd255, 1'b0);

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					load_config(16'd1, 8'hFF, 64'h0604_0302_0805_0402, {64{1'b1}});
				end
				1: begin
					send_idle_pct = 61;
					recv_stall_pct = 0;
					load_config(16'hFFFF, 8'($urandom), {64{1'b1}}, 64'd0);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 61;
					for (int b = 0; b < 8; b++)
						lims[b*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0
							: 8'($urandom_range(1, 12));
					load_config(16'($urandom_range(1, 2048)), 8'h00, lims, {$urandom, $urandom});
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
					load_config(16'($urandom), 8'($urandom), {$urandom, $urandom},
						{$urandom, $urandom});
				end
			endcase
			n = 0;
			while (n < 56) begin
				if ($urandom_range(0, 3) != 0) begin
					// enqueue burst, a credit report, then draining the same endpoint
					e = 3'($urandom_range(0, 7));
					cnt = $urandom_range(1, 12);
					repeat (cnt)
						add_event(MODE_ENQ, e, 1'($urandom), 16'($urandom), 1'($urandom),
							8'($urandom), n == 0);
					add_event(MODE_GRANT, e, 1'($urandom), 16'($urandom), 1'($urandom),
						8'($urandom), 1'b0);
					repeat (cnt) begin
						sel = $urandom_range(0, 9);
						top = (cur_credit_size == 16'd0) ? 3 : cur_credit_size * 3;
						if (top > 65535)
							top = 65535;
						if (sel == 0)
							len = 16'd0;
						else if (sel == 1)
							len = 16'hFFFF;
						else if (sel < 4)
							len = 16'($urandom);
						else
							len = 16'($urandom_range(0, top));
						add_event(MODE_DEQ, e, $urandom_range(0, 9) != 0, len,
							$urandom_range(0, 3) != 0, 8'($urandom), 1'b0);
					end
					n += 2 * cnt + 1;
				end else begin
					add_event(2'($urandom_range(0, 3)), 3'($urandom), 1'($urandom),
						16'($urandom), 1'($urandom), 8'($urandom),
						$urandom_range(0, 39) == 0);
					n++;
				end
			end
			// enough full reports to pin one endpoint's credits at the ceiling
			if (p == 3)
				repeat (258)
					add_event(MODE_GRANT, 3'd6, 1'($urandom), 16'($urandom), 1'($urandom),
						8'd255, 1'b0);
		end

		wait_idle();
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
